// ===== hdl/dense_anchor_box_iou_macros.svh =====
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef DENSE_ANCHOR_BOX_IOU_MACROS_SVH
`define DENSE_ANCHOR_BOX_IOU_MACROS_SVH

`ifndef SYNTHESIS
`define DABI_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");
`define DABI_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("forbidden condition seen");
`else
`define DABI_ASSERT(lbl, clk_s, rst_s, prop)
`define DABI_NEVER(lbl, clk_s, rst_s, expr)
`endif

`endif

// ===== hdl/dabi_pkg.sv =====
package dabi_pkg;

  localparam int COORD_W  = 16;
  localparam int GRID_W   = 10;
  localparam int STRIDE_W = 15;
  localparam int RATIO_W  = 17;
  localparam int OFS_W    = COORD_W + 1;          // edge offset plus grid origin
  localparam int PROD_W   = GRID_W + STRIDE_W;    // index times stride
  localparam int EDGE_W   = PROD_W + 3;           // placed template edge
  localparam int DIFF_W   = EDGE_W + 1;           // intersection side before clamp
  localparam int EXT_W    = COORD_W + 2;          // box side incl. one pixel
  localparam int SIDE_W   = 17;                   // positive intersection side
  localparam int AREA_W   = 2 * EXT_W;
  localparam int INTER_W  = 2 * SIDE_W;
  localparam int UNI_W    = AREA_W + 2;
  localparam int DIV_W    = 36;                   // positive union / remainder
  localparam int QUO_W    = 16;

  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;

  localparam logic [RATIO_W-1:0]  SAT_RATIO    = 17'h10000;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 15'd128;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_STRIDE_X = 2'd2,
    REG_STRIDE_Y = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic [STRIDE_W-1:0]       stride_x;
    logic [STRIDE_W-1:0]       stride_y;
  } grid_cfg_t;

  typedef struct packed {
    logic                     empty;
    logic [SIDE_W-1:0]        iw;
    logic [SIDE_W-1:0]        ih;
    logic signed [AREA_W-1:0] tmpl_area;
    logic signed [AREA_W-1:0] truth_area;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/dabi_front.sv =====
module dabi_front #(
  parameter int FRAC_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dabi_pkg::grid_cfg_t                 cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dabi_pkg::GRID_W-1:0]         grid_col,
  input  logic [dabi_pkg::GRID_W-1:0]         grid_row,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_left,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_top,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_right,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_bottom,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_left,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_top,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_right,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_bottom,
  output logic                                push_valid,
  output dabi_pkg::work_t                     push_data,
  input  logic                                push_full
);

  localparam int CW = dabi_pkg::COORD_W;
  localparam int OW = dabi_pkg::OFS_W;
  localparam int PW = dabi_pkg::PROD_W;
  localparam int EW = dabi_pkg::EDGE_W;
  localparam int DW = dabi_pkg::DIFF_W;
  localparam int XW = dabi_pkg::EXT_W;
  localparam int AW = dabi_pkg::AREA_W;
  localparam int SW = dabi_pkg::SIDE_W;

  localparam logic signed [XW-1:0] ONE_X = XW'(1 << FRAC_BITS);
  localparam logic signed [DW-1:0] ONE_D = DW'(1 << FRAC_BITS);

  logic en1, en2, en3;

  // stage 1: grid products, origin-shifted edge offsets, box sides
  logic                 s1_valid;
  logic [PW-1:0]        s1_px, s1_py;
  logic signed [OW-1:0] s1_l, s1_t, s1_r, s1_b;
  logic signed [XW-1:0] s1_tw, s1_th, s1_gw, s1_gh;
  logic signed [CW-1:0] s1_gl, s1_gt, s1_gr, s1_gb;

  // stage 2: placed template edges, box areas
  logic                 s2_valid;
  logic signed [EW-1:0] s2_x1, s2_y1, s2_x2, s2_y2;
  logic signed [AW-1:0] s2_ta, s2_ga;
  logic signed [CW-1:0] s2_gl, s2_gt, s2_gr, s2_gb;

  // stage 3: intersection sides, classified
  logic            s3_valid;
  dabi_pkg::work_t s3_work;

  logic signed [EW-1:0] gx1, gy1, gx2, gy2;
  logic signed [EW-1:0] ix_lo, ix_hi, iy_lo, iy_hi;
  logic signed [DW-1:0] iw, ih;
  logic                 iw_pos, ih_pos;

  assign en3      = !s3_valid || !push_full;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_stall = !en1;

  assign push_valid = s3_valid;
  assign push_data  = s3_work;

  always_comb begin
    gx1    = EW'(s2_gl);
    gy1    = EW'(s2_gt);
    gx2    = EW'(s2_gr);
    gy2    = EW'(s2_gb);
    ix_lo  = (s2_x1 > gx1) ? s2_x1 : gx1;
    ix_hi  = (s2_x2 < gx2) ? s2_x2 : gx2;
    iy_lo  = (s2_y1 > gy1) ? s2_y1 : gy1;
    iy_hi  = (s2_y2 < gy2) ? s2_y2 : gy2;
    iw     = DW'(ix_hi) - DW'(ix_lo) + ONE_D;
    ih     = DW'(iy_hi) - DW'(iy_lo) + ONE_D;
    iw_pos = !iw[DW-1] && (iw != '0);
    ih_pos = !ih[DW-1] && (ih != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_px <= PW'(grid_col) * PW'(cfg.stride_x);
      s1_py <= PW'(grid_row) * PW'(cfg.stride_y);
      s1_l  <= OW'(tmpl_left) + OW'(cfg.offset_x);
      s1_r  <= OW'(tmpl_right) + OW'(cfg.offset_x);
      s1_t  <= OW'(tmpl_top) + OW'(cfg.offset_y);
      s1_b  <= OW'(tmpl_bottom) + OW'(cfg.offset_y);
      // grid point cancels in the template side
      s1_tw <= XW'(tmpl_right) - XW'(tmpl_left) + ONE_X;
      s1_th <= XW'(tmpl_bottom) - XW'(tmpl_top) + ONE_X;
      s1_gw <= XW'(truth_right) - XW'(truth_left) + ONE_X;
      s1_gh <= XW'(truth_bottom) - XW'(truth_top) + ONE_X;
      s1_gl <= truth_left;
      s1_gt <= truth_top;
      s1_gr <= truth_right;
      s1_gb <= truth_bottom;
    end
    if (en2) begin
      s2_x1 <= EW'(s1_l) + EW'(s1_px);
      s2_x2 <= EW'(s1_r) + EW'(s1_px);
      s2_y1 <= EW'(s1_t) + EW'(s1_py);
      s2_y2 <= EW'(s1_b) + EW'(s1_py);
      s2_ta <= s1_tw * s1_th;
      s2_ga <= s1_gw * s1_gh;
      s2_gl <= s1_gl;
      s2_gt <= s1_gt;
      s2_gr <= s1_gr;
      s2_gb <= s1_gb;
    end
    if (en3) begin
      s3_work.empty      <= !(iw_pos && ih_pos);
      s3_work.iw         <= iw[SW-1:0];
      s3_work.ih         <= ih[SW-1:0];
      s3_work.tmpl_area  <= s2_ta;
      s3_work.truth_area <= s2_ga;
    end
  end

endmodule

// ===== hdl/dabi_queue.sv =====
`include "dense_anchor_box_iou_macros.svh"

module dabi_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  dabi_pkg::work_t     push_data,
  input  logic                pop_en,
  output dabi_pkg::work_t     head,
  output dabi_pkg::q_status_t status
);

  localparam int QP = dabi_pkg::Q_PTR_W;
  localparam int QC = dabi_pkg::Q_CNT_W;

  dabi_pkg::work_t mem [dabi_pkg::Q_DEPTH];
  logic [QP-1:0]   wr_ptr, rd_ptr;
  logic [QC-1:0]   count, count_next;
  logic            push, pop;

  assign status.full  = (count == QC'(dabi_pkg::Q_DEPTH));
  assign status.empty = (count == '0);
  assign push         = push_valid && !status.full;
  assign pop          = pop_en && !status.empty;
  assign head         = mem[rd_ptr];

  always_comb begin
    count_next = count;
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `DABI_ASSERT(a_q_count_bound, clk, rst, count <= QC'(dabi_pkg::Q_DEPTH))
  `DABI_ASSERT(a_q_push_only, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1))
  `DABI_NEVER(a_q_full_and_empty, clk, rst, status.full && status.empty)

endmodule

// ===== hdl/dabi_back.sv =====
`include "dense_anchor_box_iou_macros.svh"

module dabi_back (
  input  logic                                clk,
  input  logic                                rst,
  input  dabi_pkg::work_t                     head,
  input  dabi_pkg::q_status_t                 q_status,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dabi_pkg::RATIO_W-1:0]        overlap_ratio
);

  localparam int AW = dabi_pkg::AREA_W;
  localparam int IW = dabi_pkg::INTER_W;
  localparam int UW = dabi_pkg::UNI_W;
  localparam int DV = dabi_pkg::DIV_W;
  localparam int NS = dabi_pkg::QUO_W;
  localparam int RW = dabi_pkg::RATIO_W;

  logic eb;

  // intersection area
  logic                 b1_valid, b1_empty;
  logic [IW-1:0]        b1_inter;
  logic signed [AW-1:0] b1_ta, b1_ga;

  // union
  logic                 b2_valid, b2_zero;
  logic [IW-1:0]        b2_inter;
  logic [DV-1:0]        b2_uni;
  logic signed [UW-1:0] uni;

  // restoring divider, one quotient bit per stage; stage 0 holds the setup
  logic          d_valid [NS+1];
  logic [DV-1:0] d_rem   [NS+1];
  logic [DV-1:0] d_uni   [NS+1];
  logic [NS-1:0] d_quo   [NS+1];
  logic          d_sat   [NS+1];
  logic          d_zero  [NS+1];

  logic [DV:0]   r2      [NS+1];
  logic          ge      [NS+1];

  assign eb  = !out_valid || !out_stall;
  assign pop = eb && !q_status.empty;

  assign uni = UW'(b1_ta) + UW'(b1_ga) - UW'(b1_inter);

  always_comb begin
    r2[0] = '0;
    ge[0] = 1'b0;
    for (int k = 1; k <= NS; k++) begin
      r2[k] = {d_rem[k-1], 1'b0};
      ge[k] = (r2[k] >= {1'b0, d_uni[k-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        d_valid[k] <= 1'b0;
      end
    end else if (eb) begin
      b1_valid   <= !q_status.empty;
      b2_valid   <= b1_valid;
      d_valid[0] <= b2_valid;
      for (int k = 1; k <= NS; k++) begin
        d_valid[k] <= d_valid[k-1];
      end
      out_valid <= d_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (eb) begin
      b1_empty <= head.empty;
      b1_inter <= head.iw * head.ih;
      b1_ta    <= head.tmpl_area;
      b1_ga    <= head.truth_area;

      b2_inter <= b1_inter;
      b2_uni   <= uni[DV-1:0];
      b2_zero  <= b1_empty || uni[UW-1] || (uni == '0);

      // ratio at or above one saturates; otherwise inter < uni
      d_rem[0]  <= DV'(b2_inter);
      d_uni[0]  <= b2_uni;
      d_quo[0]  <= '0;
      d_sat[0]  <= (DV'(b2_inter) >= b2_uni);
      d_zero[0] <= b2_zero;
      for (int k = 1; k <= NS; k++) begin
        d_rem[k]  <= ge[k] ? DV'(r2[k] - {1'b0, d_uni[k-1]}) : r2[k][DV-1:0];
        d_uni[k]  <= d_uni[k-1];
        d_quo[k]  <= {d_quo[k-1][NS-2:0], ge[k]};
        d_sat[k]  <= d_sat[k-1];
        d_zero[k] <= d_zero[k-1];
      end

      priority if (d_zero[NS]) begin
        overlap_ratio <= '0;
      end else if (d_sat[NS]) begin
        overlap_ratio <= dabi_pkg::SAT_RATIO;
      end else begin
        overlap_ratio <= RW'(d_quo[NS]);
      end
    end
  end

  `DABI_ASSERT(a_ratio_bound, clk, rst, out_valid |-> (overlap_ratio <= dabi_pkg::SAT_RATIO))
  `DABI_ASSERT(a_rem_below_uni, clk, rst, (d_valid[NS] && !d_zero[NS] && !d_sat[NS]) |-> (d_rem[NS] < d_uni[NS]))

endmodule

// ===== hdl/dense_anchor_box_iou.sv =====
// Dense anchor-box IoU: places a template box at grid point offset + index * stride
// and returns intersection over union with a ground-truth box as unsigned Q1.16
// (65536 = full overlap, 0 for an empty intersection or non-positive union). It takes
// one beat per cycle while in_stall is low and returns one result per beat, in order.
// The path runs through three front stages that place the box and size the
// intersection, the 4-entry queue, two stages for the intersection and union areas, a
// divider setup stage, a 16-stage restoring divider that resolves one quotient bit per
// stage, then the output register. Registers at 0x0 offset_x, 0x4 offset_y, 0x8
// stride_x, 0xC stride_y; change them only while idle.
module dense_anchor_box_iou #(
  parameter int FRAC_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dabi_pkg::GRID_W-1:0]         grid_col,
  input  logic [dabi_pkg::GRID_W-1:0]         grid_row,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_left,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_top,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_right,
  input  logic signed [dabi_pkg::COORD_W-1:0] tmpl_bottom,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_left,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_top,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_right,
  input  logic signed [dabi_pkg::COORD_W-1:0] truth_bottom,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dabi_pkg::RATIO_W-1:0]        overlap_ratio
);

  localparam int CW = dabi_pkg::COORD_W;
  localparam int SW = dabi_pkg::STRIDE_W;

  dabi_pkg::grid_cfg_t cfg;
  dabi_pkg::reg_idx_t  reg_idx;
  logic                cfg_wr;

  logic                push_valid, push_full, pop;
  dabi_pkg::work_t     push_data, head;
  dabi_pkg::q_status_t q_status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = dabi_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x <= '0;
      cfg.offset_y <= '0;
      cfg.stride_x <= dabi_pkg::STRIDE_RESET;
      cfg.stride_y <= dabi_pkg::STRIDE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dabi_pkg::REG_OFFSET_X: cfg.offset_x <= pwdata[CW-1:0];
        dabi_pkg::REG_OFFSET_Y: cfg.offset_y <= pwdata[CW-1:0];
        dabi_pkg::REG_STRIDE_X: cfg.stride_x <= pwdata[SW-1:0];
        dabi_pkg::REG_STRIDE_Y: cfg.stride_y <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dabi_pkg::REG_OFFSET_X: prdata = {{(32-CW){1'b0}}, cfg.offset_x};
      dabi_pkg::REG_OFFSET_Y: prdata = {{(32-CW){1'b0}}, cfg.offset_y};
      dabi_pkg::REG_STRIDE_X: prdata = {{(32-SW){1'b0}}, cfg.stride_x};
      dabi_pkg::REG_STRIDE_Y: prdata = {{(32-SW){1'b0}}, cfg.stride_y};
      default:                prdata = '0;
    endcase
  end

  dabi_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .grid_col     (grid_col),
    .grid_row     (grid_row),
    .tmpl_left    (tmpl_left),
    .tmpl_top     (tmpl_top),
    .tmpl_right   (tmpl_right),
    .tmpl_bottom  (tmpl_bottom),
    .truth_left   (truth_left),
    .truth_top    (truth_top),
    .truth_right  (truth_right),
    .truth_bottom (truth_bottom),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_full    (push_full)
  );

  assign push_full = q_status.full;

  dabi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop_en     (pop),
    .head       (head),
    .status     (q_status)
  );

  dabi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .overlap_ratio (overlap_ratio)
  );

endmodule
